>>> design/slf_pkg.sv
// ----------------------------------------------------------------------------
// slf_pkg
// Shared types and constants for the straight track line fit block.
// ----------------------------------------------------------------------------
package slf_pkg;

  // Default sizes of the hit store and of one coordinate
  localparam int MAX_HITS_DEF   = 16;
  localparam int COORD_BITS_DEF = 24;

  // Fixed field and datapath widths
  localparam int FIELD_W   = 24;
  localparam int CNT_W     = 7;    // holds a hit count up to 127
  localparam int WORD_W    = 64;
  localparam int WIDE_W    = 128;
  localparam int RES_W     = 32;
  localparam int CHI_W     = 48;
  localparam int SLOPE_FR  = 20;   // Q11.20 slope
  localparam int OFFS_SH   = 12;   // 2^20 / 2^8 for the intercept divisor
  localparam int CHI_FR    = 8;

  // One input item
  typedef struct packed {
    logic signed [FIELD_W-1:0] hit_x;
    logic signed [FIELD_W-1:0] hit_y;
    logic signed [FIELD_W-1:0] hit_z;
    logic                      last_hit;
  } hit_t;

  // One result item
  typedef struct packed {
    logic signed [RES_W-1:0] slope_x;
    logic signed [RES_W-1:0] slope_y;
    logic signed [RES_W-1:0] offset_x;
    logic signed [RES_W-1:0] offset_y;
    logic [CHI_W-1:0]        chi_square;
    logic                    too_few_hits;
    logic                    degenerate;
    logic                    overflow;
  } fit_t;

  // Track handed from the front to the back
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             dropped;
  } job_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DIFF,
    BK_PROD,
    BK_PACC,
    BK_OPST,
    BK_OPWT,
    BK_DONE
  } back_state_t;

  // Fit steps after the sums, in execution order
  typedef enum logic [4:0] {
    OP_A_NZZ,
    OP_A_DZZ,
    OP_BX_N,
    OP_BX_D,
    OP_BY_N,
    OP_BY_D,
    OP_KX,
    OP_KY,
    OP_OX_M,
    OP_OX_D,
    OP_OY_M,
    OP_OY_D,
    OP_CX_N,
    OP_CX_D,
    OP_CY_N,
    OP_CY_D,
    OP_T_CXA,
    OP_T_BXX,
    OP_T_CYA,
    OP_T_BYY,
    OP_DEN,
    OP_CHI
  } op_t;

endpackage

>>> design/slf_front.sv
// ----------------------------------------------------------------------------
// slf_front
// Accepts hits, writes them into the hit store and hands each finished track
// to the back end through a one-entry job queue.
// ----------------------------------------------------------------------------
module slf_front import slf_pkg::*; #(
  parameter int MAX_HITS   = MAX_HITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int AW = $clog2(MAX_HITS),
  localparam int DW = 3 * COORD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  hit_t          in_data,
  output job_t          job,
  output logic          job_valid,
  input  logic          job_pop,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam int CW = $clog2(MAX_HITS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          jv_r, jv_nxt;
  job_t          job_r, job_nxt;
  logic          accept, room;
  logic [DW-1:0] mem [MAX_HITS];
  logic [DW-1:0] rd_data_r;
  logic [DW-1:0] wr_word;

  // Store is held by a pending track until the back end has summed it
  assign accept = push && !jv_r;
  assign room   = cnt_r < CW'(MAX_HITS);
  assign full   = jv_r;

  assign wr_word = {COORD_BITS'($unsigned(in_data.hit_x)),
                    COORD_BITS'($unsigned(in_data.hit_y)),
                    COORD_BITS'($unsigned(in_data.hit_z))};

  // Count, drop flag and job hand-off
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    jv_nxt   = jv_r;
    job_nxt  = job_r;
    if (job_pop) begin
      jv_nxt = 1'b0;
    end
    if (accept) begin
      if (in_data.last_hit) begin
        job_nxt.count   = CNT_W'(cnt_r + CW'(room));
        job_nxt.dropped = drop_r | !room;
        jv_nxt          = 1'b1;
        cnt_nxt         = '0;
        drop_nxt        = 1'b0;
      end else begin
        cnt_nxt  = cnt_r + CW'(room);
        drop_nxt = drop_r | !room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
      jv_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
      jv_r   <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  // Hit store: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[cnt_r[AW-1:0]] <= wr_word;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data   = rd_data_r;
  assign job       = job_r;
  assign job_valid = jv_r;

endmodule

>>> design/slf_mul.sv
// ----------------------------------------------------------------------------
// slf_mul
// Shift-add multiplier, 64 x 64 to 128 bits unsigned, one bit per cycle.
// ----------------------------------------------------------------------------
module slf_mul import slf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] op_a,
  input  logic [WORD_W-1:0] op_b,
  output logic              done,
  output logic [WIDE_W-1:0] prod
);

  localparam int NW = $clog2(WORD_W);

  logic [WIDE_W-1:0] acc_r;
  logic [WIDE_W-1:0] mcand_r;
  logic [WORD_W-1:0] mplier_r;
  logic [NW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NW'(WORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One partial product per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= WIDE_W'(op_a);
      mplier_r <= op_b;
    end else if (run_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> design/slf_div.sv
// ----------------------------------------------------------------------------
// slf_div
// Restoring divider, 128 by 128 bits, one quotient bit per cycle, then a
// round-to-nearest step (ties up). A zero divisor gives zero.
// ----------------------------------------------------------------------------
module slf_div import slf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] num,
  input  logic [WIDE_W-1:0] den,
  output logic              done,
  output logic [WIDE_W-1:0] quo
);

  localparam int NW = $clog2(WIDE_W);

  logic [WIDE_W-1:0] num_r, den_r, rem_r, q_r, res_r;
  logic [WIDE_W-1:0] r1, rem2;
  logic [NW-1:0]     cnt_r;
  logic              run_r, rnd_r, done_r;
  logic              ge;

  // Partial remainder step; the shift drops the top bit as a 128-bit word
  assign r1   = {rem_r[WIDE_W-2:0], num_r[WIDE_W-1]};
  assign ge   = r1 >= den_r;
  assign rem2 = {rem_r[WIDE_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      rnd_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == NW'(WIDE_W - 1)) begin
          run_r <= 1'b0;
          rnd_r <= 1'b1;
        end
      end else if (rnd_r) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      num_r <= num_r << 1;
      if (ge) begin
        rem_r <= r1 - den_r;
        q_r   <= {q_r[WIDE_W-2:0], 1'b1};
      end else begin
        rem_r <= r1;
        q_r   <= {q_r[WIDE_W-2:0], 1'b0};
      end
    end else if (rnd_r) begin
      if (den_r == '0) begin
        res_r <= '0;
      end else begin
        res_r <= q_r + WIDE_W'(rem2 >= den_r);
      end
    end
  end

  assign done = done_r;
  assign quo  = res_r;

endmodule

>>> design/slf_back.sv
// ----------------------------------------------------------------------------
// slf_back
// Fit sequencer: sums the stored hits of one track, then runs the slope,
// intercept and chi-square steps on a shared multiplier and divider.
// ----------------------------------------------------------------------------
module slf_back import slf_pkg::*; #(
  parameter int MAX_HITS   = MAX_HITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int AW = $clog2(MAX_HITS),
  localparam int DW = 3 * COORD_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  job_t          job,
  input  logic          job_valid,
  output logic          job_pop,
  output logic [AW-1:0] rd_addr,
  input  logic [DW-1:0] rd_data,
  output logic          res_valid,
  output fit_t          res,
  input  logic          res_ready
);

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 2;

  back_state_t state_r, state_nxt;
  op_t         op_r;

  logic [AW-1:0]    idx_r;
  logic [CNT_W-1:0] n_r;
  logic             drop_r, few_r, degen_r;
  logic [2:0]       sub_r;

  logic signed [CB-1:0] bx0_r, by0_r, bz0_r;
  logic signed [CB:0]   dx_r, dy_r, dz_r;
  logic [WORD_W-1:0]    prod_r;
  logic [WORD_W-1:0]    sx_r, sy_r, sz_r, dsx_r, dsy_r, dsz_r;
  logic [WORD_W-1:0]    szz_r, szx_r, szy_r, sxx_r, syy_r;
  logic [WORD_W-1:0]    a_r, bx_r, by_r, cx_r, cy_r, num_r;
  logic [WIDE_W-1:0]    tot_r, den_r;
  logic [RES_W-1:0]     kx_r, ky_r, ox_r, oy_r;
  logic [CHI_W-1:0]     chi_r;

  logic signed [CB-1:0] hx, hy, hz, ux, uy, uz;
  logic signed [CB:0]   ma, mb;
  logic signed [PW-1:0] pfull;
  logic [WORD_W-1:0]    n64, magbx, magby, magnum;
  logic [CNT_W:0]       nf;
  logic [2*CNT_W:0]     nn;
  logic [WORD_W-1:0]    mul_a, mul_b;
  logic [WIDE_W-1:0]    div_n, div_d, mprod, dquo;
  logic                 mul_start, div_start, mul_done, div_done;
  logic                 op_div, op_done, last_hit_rd, op_final;

  function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Rounded quotient with sign, saturated to 32-bit signed
  function automatic logic [RES_W-1:0] sat32(input logic neg,
                                             input logic [WIDE_W-1:0] q);
    logic [RES_W-1:0] lo;
    lo = q[RES_W-1:0];
    if (neg) begin
      if (q[WIDE_W-1:RES_W] != '0 || lo > {1'b1, {(RES_W-1){1'b0}}}) begin
        return {1'b1, {(RES_W-1){1'b0}}};
      end
      return ~lo + 1'b1;
    end
    if (q[WIDE_W-1:RES_W-1] != '0) begin
      return {1'b0, {(RES_W-1){1'b1}}};
    end
    return lo;
  endfunction

  // Hit read back from the store
  assign hx = rd_data[DW-1:2*CB];
  assign hy = rd_data[2*CB-1:CB];
  assign hz = rd_data[CB-1:0];
  assign ux = (idx_r == '0) ? hx : bx0_r;
  assign uy = (idx_r == '0) ? hy : by0_r;
  assign uz = (idx_r == '0) ? hz : bz0_r;

  // Small multiplier of the accumulation phase
  always_comb begin
    case (sub_r)
      3'd0:    begin ma = dz_r; mb = dz_r; end
      3'd1:    begin ma = dz_r; mb = dx_r; end
      3'd2:    begin ma = dz_r; mb = dy_r; end
      3'd3:    begin ma = dx_r; mb = dx_r; end
      default: begin ma = dy_r; mb = dy_r; end
    endcase
  end
  assign pfull = ma * mb;

  assign n64    = WORD_W'(n_r);
  assign magbx  = mag64(bx_r);
  assign magby  = mag64(by_r);
  assign magnum = mag64(num_r);
  assign nf     = {n_r, 1'b0} - (CNT_W+1)'(4);
  assign nn     = n_r * nf;

  assign rd_addr     = idx_r;
  assign last_hit_rd = (CNT_W'(idx_r) + CNT_W'(1)) == n_r;

  // Operand decoder for the fit steps
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    div_n  = '0;
    div_d  = '0;
    op_div = 1'b0;
    unique case (op_r) inside
      OP_A_NZZ: begin mul_a = n64;   mul_b = szz_r; end
      OP_A_DZZ: begin mul_a = dsz_r; mul_b = dsz_r; end
      OP_BX_N:  begin mul_a = n64;   mul_b = szx_r; end
      OP_BX_D:  begin mul_a = dsz_r; mul_b = dsx_r; end
      OP_BY_N:  begin mul_a = n64;   mul_b = szy_r; end
      OP_BY_D:  begin mul_a = dsz_r; mul_b = dsy_r; end
      OP_KX: begin
        op_div = 1'b1;
        div_n  = WIDE_W'(magbx) << SLOPE_FR;
        div_d  = WIDE_W'(a_r);
      end
      OP_KY: begin
        op_div = 1'b1;
        div_n  = WIDE_W'(magby) << SLOPE_FR;
        div_d  = WIDE_W'(a_r);
      end
      OP_OX_M: begin mul_a = WORD_W'($signed(kx_r)); mul_b = sz_r; end
      OP_OY_M: begin mul_a = WORD_W'($signed(ky_r)); mul_b = sz_r; end
      OP_OX_D, OP_OY_D: begin
        op_div = 1'b1;
        div_n  = WIDE_W'(magnum);
        div_d  = WIDE_W'(n_r) << OFFS_SH;
      end
      OP_CX_N:  begin mul_a = n64;   mul_b = sxx_r; end
      OP_CX_D:  begin mul_a = dsx_r; mul_b = dsx_r; end
      OP_CY_N:  begin mul_a = n64;   mul_b = syy_r; end
      OP_CY_D:  begin mul_a = dsy_r; mul_b = dsy_r; end
      OP_T_CXA: begin mul_a = cx_r;  mul_b = a_r;   end
      OP_T_BXX: begin mul_a = magbx; mul_b = magbx; end
      OP_T_CYA: begin mul_a = cy_r;  mul_b = a_r;   end
      OP_T_BYY: begin mul_a = magby; mul_b = magby; end
      OP_DEN:   begin mul_a = a_r;   mul_b = WORD_W'(nn); end
      OP_CHI: begin
        op_div = 1'b1;
        div_n  = tot_r << CHI_FR;
        div_d  = den_r;
      end
      default: begin end
    endcase
  end

  assign op_done = op_div ? div_done : mul_done;

  // Last step of the track: equal z, two hits, or chi-square written
  always_comb begin
    op_final = 1'b0;
    if (op_r == OP_BY_D && a_r == '0) begin
      op_final = 1'b1;
    end
    if (op_r == OP_OY_D && n_r == CNT_W'(2)) begin
      op_final = 1'b1;
    end
    if (op_r == OP_CHI) begin
      op_final = 1'b1;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          if (job.count < CNT_W'(2)) begin
            job_pop   = 1'b1;
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ: state_nxt = BK_DIFF;
      BK_DIFF: state_nxt = BK_PROD;
      BK_PROD: begin
        if (sub_r == 3'd4) begin
          state_nxt = BK_PACC;
        end
      end
      BK_PACC: begin
        if (last_hit_rd) begin
          job_pop   = 1'b1;
          state_nxt = BK_OPST;
        end else begin
          state_nxt = BK_READ;
        end
      end
      BK_OPST: begin
        mul_start = !op_div;
        div_start = op_div;
        state_nxt = BK_OPWT;
      end
      BK_OPWT: begin
        if (op_done) begin
          state_nxt = op_final ? BK_DONE : BK_OPST;
        end
      end
      BK_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        n_r     <= job.count;
        drop_r  <= job.dropped;
        few_r   <= job.count < CNT_W'(2);
        degen_r <= 1'b0;
        idx_r   <= '0;
        op_r    <= OP_A_NZZ;
        {sx_r, sy_r, sz_r, dsx_r, dsy_r, dsz_r} <= '0;
        {szz_r, szx_r, szy_r, sxx_r, syy_r} <= '0;
        {kx_r, ky_r, ox_r, oy_r, chi_r} <= '0;
      end
      BK_DIFF: begin
        bx0_r <= ux;
        by0_r <= uy;
        bz0_r <= uz;
        dx_r  <= {hx[CB-1], hx} - {ux[CB-1], ux};
        dy_r  <= {hy[CB-1], hy} - {uy[CB-1], uy};
        dz_r  <= {hz[CB-1], hz} - {uz[CB-1], uz};
        sx_r  <= sx_r + WORD_W'(hx);
        sy_r  <= sy_r + WORD_W'(hy);
        sz_r  <= sz_r + WORD_W'(hz);
        dsx_r <= dsx_r + WORD_W'($signed({hx[CB-1], hx} - {ux[CB-1], ux}));
        dsy_r <= dsy_r + WORD_W'($signed({hy[CB-1], hy} - {uy[CB-1], uy}));
        dsz_r <= dsz_r + WORD_W'($signed({hz[CB-1], hz} - {uz[CB-1], uz}));
        sub_r <= '0;
      end
      BK_PROD: begin
        prod_r <= WORD_W'(pfull);
        sub_r  <= sub_r + 1'b1;
        case (sub_r)
          3'd1:    szz_r <= szz_r + prod_r;
          3'd2:    szx_r <= szx_r + prod_r;
          3'd3:    szy_r <= szy_r + prod_r;
          3'd4:    sxx_r <= sxx_r + prod_r;
          default: begin end
        endcase
      end
      BK_PACC: begin
        syy_r <= syy_r + prod_r;
        idx_r <= idx_r + 1'b1;
      end
      BK_OPWT: begin
        if (op_done) begin
          op_r <= op_t'(op_r + 5'd1);
          unique case (op_r)
            OP_A_NZZ: a_r   <= mprod[WORD_W-1:0];
            OP_A_DZZ: a_r   <= a_r - mprod[WORD_W-1:0];
            OP_BX_N:  bx_r  <= mprod[WORD_W-1:0];
            OP_BX_D:  bx_r  <= bx_r - mprod[WORD_W-1:0];
            OP_BY_N:  by_r  <= mprod[WORD_W-1:0];
            OP_BY_D: begin
              by_r    <= by_r - mprod[WORD_W-1:0];
              degen_r <= (a_r == '0) || (n_r == CNT_W'(2));
            end
            OP_KX:    kx_r  <= sat32(bx_r[WORD_W-1], dquo);
            OP_KY:    ky_r  <= sat32(by_r[WORD_W-1], dquo);
            OP_OX_M:  num_r <= (sx_r << SLOPE_FR) - mprod[WORD_W-1:0];
            OP_OX_D:  ox_r  <= sat32(num_r[WORD_W-1], dquo);
            OP_OY_M:  num_r <= (sy_r << SLOPE_FR) - mprod[WORD_W-1:0];
            OP_OY_D:  oy_r  <= sat32(num_r[WORD_W-1], dquo);
            OP_CX_N:  cx_r  <= mprod[WORD_W-1:0];
            OP_CX_D:  cx_r  <= cx_r - mprod[WORD_W-1:0];
            OP_CY_N:  cy_r  <= mprod[WORD_W-1:0];
            OP_CY_D:  cy_r  <= cy_r - mprod[WORD_W-1:0];
            OP_T_CXA: tot_r <= mprod;
            OP_T_BXX: tot_r <= tot_r - mprod;
            OP_T_CYA: tot_r <= tot_r + mprod;
            OP_T_BYY: tot_r <= tot_r - mprod;
            OP_DEN:   den_r <= mprod;
            OP_CHI: begin
              if (dquo[WIDE_W-1:CHI_W] != '0) begin
                chi_r <= '1;
              end else begin
                chi_r <= dquo[CHI_W-1:0];
              end
            end
            default: begin end
          endcase
        end
      end
      default: begin end
    endcase
  end

  slf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mprod)
  );

  slf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (dquo)
  );

  // Result item
  assign res.slope_x      = kx_r;
  assign res.slope_y      = ky_r;
  assign res.offset_x     = ox_r;
  assign res.offset_y     = oy_r;
  assign res.chi_square   = chi_r;
  assign res.too_few_hits = few_r;
  assign res.degenerate   = degen_r;
  assign res.overflow     = drop_r;

endmodule

>>> design/straight_track_line_fit.sv
// ----------------------------------------------------------------------------
// straight_track_line_fit
// Least-squares straight line fit of one track of 3-D hits.
// ----------------------------------------------------------------------------
// Hits enter one per cycle while full is low and are written into a MAX_HITS
// deep store; the item with last_hit set closes the track and one fit result
// follows it. The fit of a track first forms the sums, one stored hit after
// another (store read, differences, five multiply-accumulates on one small
// multiplier, final accumulate), then runs up to 17 products on a shared
// bit-serial 64x64 multiplier and 5 rounded divisions on a shared bit-serial
// 128-bit divider; fewer steps run for two hits or equal z, and none for
// fewer than two hits.
// While the fit of one track runs, hits of the next track are taken; full is
// high from the closing hit of a track until its hits have been summed.
// Results wait in an output register and are taken with pop.
// ----------------------------------------------------------------------------
module straight_track_line_fit import slf_pkg::*; #(
  parameter int MAX_HITS   = MAX_HITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  hit_t in_data,
  output logic empty,
  input  logic pop,
  output fit_t out_data
);

  localparam int AW = $clog2(MAX_HITS);
  localparam int DW = 3 * COORD_BITS;

  job_t          job;
  logic          job_valid, job_pop;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          res_valid, res_ready;
  fit_t          res;
  logic          ov_r, ov_nxt;
  fit_t          od_r;

  slf_front #(
    .MAX_HITS   (MAX_HITS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  slf_back #(
    .MAX_HITS   (MAX_HITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register
  assign res_ready = !ov_r || pop;

  always_comb begin
    ov_nxt = ov_r;
    if (pop) begin
      ov_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      od_r <= res;
    end
  end

  assign empty    = !ov_r;
  assign out_data = od_r;

endmodule
